// File: rtl/pleu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pleu_pkg;

   // Default number of list entries.
   localparam int CAPACITY_DEF = 64;

   // Field widths of one request and one response.
   localparam int OP_W    = 2;
   localparam int POS_W   = 8;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 7;
   localparam int STAT_W  = 2;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_BITS  = OP_W + POS_W + VALUE_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = VALUE_W + LEN_W + STAT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [STAT_W-1:0] status_type;

   // Operation codes.
   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_DELETE = 2'd1;
   localparam op_type OP_GET    = 2'd2;

   // Status codes.
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// File: rtl/positional_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Positional list engine. The block holds an ordered list of up to CAPACITY
// signed 32-bit values, addressed by 1-based position, in a single
// synchronous RAM. Each request transfer carries one operation: insert a
// value at position 1 to length+1, delete the entry at position 1 to length,
// or get the entry at a position. Exactly one response transfer follows each
// request; it carries the value read by a successful get (zero otherwise),
// the list length after the operation, and a status of ok, position out of
// range, or list full. A rejected operation leaves the list untouched. The
// block works on one request at a time. Inserts and deletes move the tail of
// the list through the RAM one entry per cycle, bounded by the single write
// port. The RAM needs no clearing after reset: only entries below the
// current length are ever read. A finished response waits in an output
// register, so the request side can be idle again while the downstream
// side stalls, until the next response is ready.
module positional_list_engine_unit
   import pleu_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Fields from bit 0 up: operation[1:0], position[9:2], value[41:10].
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0 up: read_value[31:0], length[38:32], status[40:39].
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_FINAL = 3'd2;
   localparam logic [2:0] S_GETRD = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      end_ff, end_in;
   logic                  ins_ff, ins_in;
   logic                  wv_ff, wv_in;
   logic [AW-1:0]         wa_ff, wa_in;
   logic [VALUE_W-1:0]    val_ff, val_in;
   logic [VALUE_W-1:0]    res_value_ff, res_value_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Request fields.
   op_type                req_op;
   logic [POS_W-1:0]      req_pos;
   logic [VALUE_W-1:0]    req_value;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic                  ins_range;
   logic                  acc_range;
   logic                  list_full;
   logic                  req_fire;

   // RAM port signals.
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_W-1:0]    wr_data;
   logic [AW-1:0]         rd_addr;
   logic [VALUE_W-1:0]    rd_data;

   assign req_op    = req_tdata[OP_W-1:0];
   assign req_pos   = req_tdata[OP_W +: POS_W];
   assign req_value = req_tdata[OP_W+POS_W +: VALUE_W];

   assign pos_ext   = CMP_W'(req_pos);
   assign cnt_ext   = CMP_W'(count_ff);
   // Insert may address one place past the end; delete and get may not.
   assign ins_range = (req_pos == '0) || (pos_ext > cnt_ext + CMP_W'(1));
   assign acc_range = (req_pos == '0) || (pos_ext > cnt_ext);
   assign list_full = (count_ff == CNT_W'(CAPACITY));

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pleu_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      ins_in        = ins_ff;
      wv_in         = 1'b0;
      wa_in         = wa_ff;
      val_in        = val_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      // A pending shift write lands in the cycle after its read was issued.
      wr_en   = wv_ff;
      wr_addr = wa_ff;
      wr_data = rd_data;
      rd_addr = AW'(pos_ext - CMP_W'(1));

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_value_in  = '0;
               res_status_in = ST_RANGE;
               state_in      = S_RESP;
               case (req_op)
                  OP_INSERT: begin
                     if (ins_range) begin
                        res_status_in = ST_RANGE;
                     end else if (list_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        // Walk from the end down to the insert point.
                        res_status_in = ST_OK;
                        idx_in        = count_ff;
                        end_in        = CNT_W'(pos_ext - CMP_W'(1));
                        ins_in        = 1'b1;
                        val_in        = req_value;
                        count_in      = count_ff + CNT_W'(1);
                        state_in      = S_SHIFT;
                     end
                  end
                  OP_DELETE: begin
                     if (!acc_range) begin
                        // Walk from the gap up to the last entry.
                        res_status_in = ST_OK;
                        idx_in        = CNT_W'(pos_ext - CMP_W'(1));
                        end_in        = count_ff - CNT_W'(1);
                        ins_in        = 1'b0;
                        count_in      = count_ff - CNT_W'(1);
                        state_in      = S_SHIFT;
                     end
                  end
                  OP_GET: begin
                     if (!acc_range) begin
                        res_status_in = ST_OK;
                        state_in      = S_GETRD;
                     end
                  end
                  default: begin
                     res_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            if (idx_ff != end_ff) begin
               wv_in = 1'b1;
               wa_in = idx_ff[AW-1:0];
               if (ins_ff) begin
                  rd_addr = AW'(idx_ff - CNT_W'(1));
                  idx_in  = idx_ff - CNT_W'(1);
               end else begin
                  rd_addr = AW'(idx_ff + CNT_W'(1));
                  idx_in  = idx_ff + CNT_W'(1);
               end
            end else begin
               state_in = ins_ff ? S_FINAL : S_RESP;
            end
         end
         S_FINAL: begin
            wr_en    = 1'b1;
            wr_addr  = end_ff[AW-1:0];
            wr_data  = val_ff;
            state_in = S_RESP;
         end
         S_GETRD: begin
            res_value_in = rd_data;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_status_ff, LEN_W'(count_ff), res_value_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wv_ff        <= wv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      ins_ff        <= ins_in;
      wa_ff         <= wa_in;
      val_ff        <= val_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // The list never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length exceeds capacity");

   // Every RAM write lands inside the list as it stands after the operation.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) < count_ff))
      else $error("RAM write outside the list");

   // The length changes only in the cycle after a request transfer.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(req_fire)) |-> $stable(count_ff))
      else $error("length changed without a request");

   // A new response appears only when the sequencer leaves its response state.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_RESP))
      else $error("response raised outside the response state");

   // No shift write may still be pending while a new request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !wv_ff)
      else $error("request taken with a shift write pending");

endmodule

`default_nettype wire

// File: rtl/pleu_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pleu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: bench/positional_list_engine_unit_test.sv
`timescale 1ns / 1ps

module positional_list_engine_unit_test
   import pleu_pkg::*;
;

   // The list size under test. The bench builds the block at the package
   // default so that the full-list case stays reachable in a short run.
   localparam int LIST_CAPACITY = CAPACITY_DEF;

   // Operation code three has no meaning; the block must reject it.
   localparam op_type OP_UNUSED = 2'd3;

   // Worst-case item latency in cycles, a shift of the whole list plus margin.
   localparam int ITEM_LATENCY = LIST_CAPACITY + 8;

   // Length of the long receiver hold-off that lets the block back up.
   localparam int LONG_STALL = 400;

   // One pending list request, as the driver will send it.
   typedef struct {
      op_type      op;
      logic [7:0]  position;
      logic [31:0] value;
   } list_request_type;

   // One expected response, field by field.
   typedef struct {
      logic [31:0] read_value;
      logic [6:0]  length;
      status_type  status;
   } list_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   // Requests waiting for the driver, and responses the list should give.
   list_request_type request_queue[$];
   list_result_type  expected_results[$];

   // Our own copy of the list contents, kept in position order.
   logic [31:0] list_shadow[$];

   // Length as the stimulus generator sees it, so it can aim positions.
   int gen_length = 0;

   int items_queued   = 0;
   int results_seen   = 0;
   int mismatch_count = 0;

   // Per-cycle idle chances, in percent, for each side of the block.
   int sender_idle_pct = 31;
   int rsp_idle_pct    = 49;

   // Long hold-off bookkeeping. The stimulus asks by bumping stall_asks; the
   // hold-off process serves each request once and counts the cycles down.
   int stall_asks   = 0;
   int stall_served = 0;
   int stall_left   = 0;

   // Set at a rising edge when the driver's current request was taken.
   logic req_taken = 1'b0;

   positional_list_engine_unit #(
      .CAPACITY(LIST_CAPACITY)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   always #1 clock = ~clock;

   // Prints one line per mismatch and keeps the count for the final verdict.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // Applies one request to the shadow list and returns the response the
   // block owes for it. A rejected request leaves the shadow untouched.
   function automatic list_result_type apply_list_op(input op_type op,
                                                     input logic [7:0] position,
                                                     input logic [31:0] value);
      list_result_type res;
      int              held;
      held           = list_shadow.size();
      res.read_value = '0;
      res.status     = ST_RANGE;
      case (op)
         OP_INSERT: begin
            if (position == 0 || position > held + 1) begin
               res.status = ST_RANGE;
            end else if (held >= LIST_CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               list_shadow.insert(position - 1, value);
               res.status = ST_OK;
            end
         end
         OP_DELETE: begin
            if (position != 0 && position <= held) begin
               list_shadow.delete(position - 1);
               res.status = ST_OK;
            end
         end
         OP_GET: begin
            if (position != 0 && position <= held) begin
               res.read_value = list_shadow[position - 1];
               res.status     = ST_OK;
            end
         end
         default: begin
            res.status = ST_RANGE;
         end
      endcase
      res.length = 7'(list_shadow.size());
      return res;
   endfunction

   // Queues a request and tracks the length it will leave behind, so that
   // later requests can be aimed at valid positions.
   task automatic queue_request(input op_type op, input int position,
                                input logic [31:0] value);
      list_request_type item;
      item.op       = op;
      item.position = 8'(position);
      item.value    = value;
      request_queue.push_back(item);
      items_queued++;
      if (op == OP_INSERT && item.position != 0 && item.position <= gen_length + 1
          && gen_length < LIST_CAPACITY) begin
         gen_length++;
      end else if (op == OP_DELETE && item.position != 0
                   && item.position <= gen_length) begin
         gen_length--;
      end
   endtask

   // Values lean on the sign boundaries now and then.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed operations at valid positions, with some noise that
   // covers every code and every position bit.
   task automatic queue_random_request();
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         queue_request(op_type'($urandom_range(3)), $urandom_range(255), $urandom);
      end else if (r < 45) begin
         queue_request(OP_INSERT, $urandom_range(gen_length + 1, 1), pick_value());
      end else if (r < 75) begin
         queue_request(OP_DELETE, (gen_length == 0) ? 1 : $urandom_range(gen_length, 1),
                       $urandom);
      end else begin
         queue_request(OP_GET, (gen_length == 0) ? 1 : $urandom_range(gen_length, 1),
                       $urandom);
      end
   endtask

   // Sender pause: nothing new goes out until every response is back.
   task automatic wait_for_quiet();
      while (results_seen != items_queued) @(posedge clock);
   endtask

   // Sample the request handshake. The prediction is made at the moment the
   // block takes the transfer, so it follows the accepted order exactly.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_results.push_back(apply_list_op(req_tdata[OP_W-1:0],
                                                  req_tdata[OP_W +: POS_W],
                                                  req_tdata[OP_W+POS_W +: VALUE_W]));
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   // Request driver. It only moves on once the current transfer was taken,
   // and it may drop valid between items when the sender idles.
   always @(negedge clock) begin : request_driver
      list_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            item = request_queue.pop_front();
            req_tdata  <= REQ_DATA_W'({item.value, item.position, item.op});
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long hold-off counter, kept apart from the receiver's random idling.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_asks != stall_served) begin
         stall_left   <= LONG_STALL;
         stall_served <= stall_served + 1;
      end
   end

   // Response ready, lowered during a long hold-off or at random.
   always @(negedge clock) begin
      rsp_tready <= (stall_left == 0) && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Response monitor: every transfer is matched against the oldest
   // expectation, one field at a time.
   always @(posedge clock) begin : response_monitor
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected, data %h",
                                      rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[31:0] !== want.read_value)
               report_mismatch($sformatf("read_value %h, expected %h",
                                         rsp_tdata[31:0], want.read_value));
            if (rsp_tdata[38:32] !== want.length)
               report_mismatch($sformatf("length %0d, expected %0d",
                                         rsp_tdata[38:32], want.length));
            if (rsp_tdata[40:39] !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_tdata[40:39], want.status));
         end
      end
   end

   // Stimulus and run control.
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on an empty list: empty-list rejects, position zero,
      // positions past the end, the sign extremes, inserts at front, middle
      // and end, the unused operation code, and deletes at every place.
      queue_request(OP_GET,    1,   32'h0);
      queue_request(OP_DELETE, 1,   32'h0);
      queue_request(OP_INSERT, 0,   32'h1234_5678);
      queue_request(OP_INSERT, 2,   32'h1234_5678);
      queue_request(OP_INSERT, 1,   32'h8000_0000);
      queue_request(OP_INSERT, 2,   32'h7FFF_FFFF);
      queue_request(OP_INSERT, 1,   32'hFFFF_FFFF);
      queue_request(OP_INSERT, 2,   32'h0000_0000);
      queue_request(OP_GET,    1,   32'hFFFF_FFFF);
      queue_request(OP_GET,    2,   32'h0);
      queue_request(OP_GET,    3,   32'h0);
      queue_request(OP_GET,    4,   32'h0);
      queue_request(OP_GET,    5,   32'h0);
      queue_request(OP_GET,    0,   32'h0);
      queue_request(OP_DELETE, 0,   32'h0);
      queue_request(OP_DELETE, 5,   32'h0);
      queue_request(OP_UNUSED, 1,   32'hA5A5_A5A5);
      queue_request(OP_INSERT, 255, 32'h5A5A_5A5A);
      queue_request(OP_DELETE, 2,   32'h0);
      queue_request(OP_GET,    2,   32'h0);
      queue_request(OP_DELETE, 3,   32'h0);
      queue_request(OP_DELETE, 1,   32'h0);
      queue_request(OP_GET,    1,   32'h0);

      // First random phase. The long hold-off starts while the sender still
      // has plenty to offer, so the block fills up and stalls its input.
      repeat (130) queue_random_request();
      stall_asks++;
      wait_for_quiet();

      // Second phase with the idle rates swapped: fill the list to capacity,
      // hit it with full and out-of-range inserts, then mixed traffic.
      sender_idle_pct = 49;
      rsp_idle_pct    = 31;
      while (gen_length < LIST_CAPACITY)
         queue_request(OP_INSERT, $urandom_range(gen_length + 1, 1), pick_value());
      queue_request(OP_INSERT, 1, 32'h1111_1111);
      queue_request(OP_INSERT, LIST_CAPACITY + 1, 32'h2222_2222);
      queue_request(OP_INSERT, LIST_CAPACITY + 2, 32'h3333_3333);
      queue_request(OP_INSERT, 0, 32'h4444_4444);
      queue_request(OP_GET, LIST_CAPACITY, 32'h0);
      queue_request(OP_DELETE, 1, 32'h0);
      repeat (110) queue_random_request();
      wait_for_quiet();

      // Last phase at full speed on both sides.
      sender_idle_pct = 0;
      rsp_idle_pct    = 0;
      repeat (100) queue_random_request();
      wait_for_quiet();
      repeat (ITEM_LATENCY) @(posedge clock);

      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived",
                                   expected_results.size()));
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
